// ===== sv/wsle_pkg.sv =====
// ----------------------------------------------------------------------------
// wsle_pkg
// Shared types and constants of the weighted species energy sampler.
// ----------------------------------------------------------------------------
package wsle_pkg;

    localparam int SPECIES     = 4;
    localparam int ENERGY_BITS = 24;
    localparam int CAP         = (SPECIES < 4) ? SPECIES : 4;
    localparam int FRAC        = 16;
    localparam int SEARCH      = 16;

    localparam logic [2:0] REG_ENTRY0 = 3'd0;
    localparam logic [2:0] REG_ENTRY1 = 3'd1;
    localparam logic [2:0] REG_ENTRY2 = 3'd2;
    localparam logic [2:0] REG_ENTRY3 = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;
    localparam logic [2:0] REG_FLOOR  = 3'd5;

    typedef struct packed {
        logic [3:0][63:0] entry;
        logic [2:0]       count;
        logic [23:0]      floor_kev;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  sel;
        logic        status;
        logic [23:0] lo;
        logic [23:0] hi;
        logic [15:0] uen;
    } t_job;

    typedef struct packed {
        logic [1:0]  sel;
        logic        status;
        logic [23:0] lo;
        logic [15:0] uen;
        logic [4:0]  n_lo;
        logic [4:0]  n_hi;
        logic [16:0] m_hi;
        logic [15:0] r_lo;
        logic [6:0]  k;
        logic [15:0] f;
        logic [16:0] slo;
        logic [16:0] shi;
        logic [16:0] mid;
    } t_ctx;

endpackage

// ===== sv/wsle_if.sv =====
// ----------------------------------------------------------------------------
// wsle_if
// Valid/ready channels for the sample words and the result words.
// ----------------------------------------------------------------------------
interface wsle_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] u_select;
    logic [15:0] u_energy;
    modport source (output valid, output u_select, output u_energy, input ready);
    modport sink   (input valid, input u_select, input u_energy, output ready);
endinterface

interface wsle_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  species;
    logic [23:0] energy_kev;
    logic        status;
    modport source (output valid, output species, output energy_kev, output status,
                    input ready);
    modport sink   (input valid, input species, input energy_kev, input status,
                    output ready);
endinterface

// ===== sv/wsle_front.sv =====
// ----------------------------------------------------------------------------
// wsle_front
// Accepts a sample word, picks the species and its energy bounds.
// ----------------------------------------------------------------------------
module wsle_front (
    input  wsle_pkg::t_cfg i_cfg,
    wsle_in_if.sink        i_in,
    input  logic           i_full,
    output logic           o_push,
    output wsle_pkg::t_job o_job
);

    logic [2:0]  w_cnt;
    logic [1:0]  w_sel;
    logic [63:0] w_ent;
    logic [23:0] w_lo;

    always_comb begin
        w_cnt = i_cfg.count;
        if (w_cnt == 3'd0) begin
            w_cnt = 3'd1;
        end
        if (w_cnt > 3'(wsle_pkg::CAP)) begin
            w_cnt = 3'(wsle_pkg::CAP);
        end
        w_sel = 2'(w_cnt - 3'd1);
        for (int i = wsle_pkg::CAP - 1; i >= 0; i--) begin
            if ((3'(i) < w_cnt) && (i_cfg.entry[i][63:48] >= i_in.u_select)) begin
                w_sel = 2'(i);
            end
        end
        w_ent = i_cfg.entry[w_sel];
        w_lo  = w_ent[47:24];
        if (w_lo < i_cfg.floor_kev) begin
            w_lo = i_cfg.floor_kev;
        end
        o_job.sel    = w_sel;
        o_job.lo     = w_lo;
        o_job.hi     = w_ent[23:0];
        o_job.uen    = i_in.u_energy;
        o_job.status = (w_lo == 24'd0);
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

endmodule

// ===== sv/wsle_queue.sv =====
// ----------------------------------------------------------------------------
// wsle_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module wsle_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsle_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output wsle_pkg::t_job o_job
);

    wsle_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== sv/wsle_frac_pipe.sv =====
// ----------------------------------------------------------------------------
// wsle_frac_pipe
// Fractional log2 of a Q16 mantissa, one squaring per stage.
// ----------------------------------------------------------------------------
module wsle_frac_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [16:0]    i_y,
    input  wsle_pkg::t_ctx i_ctx,
    output logic           o_valid,
    output logic [15:0]    o_r,
    output wsle_pkg::t_ctx o_ctx
);

    logic           r_v   [wsle_pkg::FRAC];
    logic [16:0]    r_y   [wsle_pkg::FRAC];
    logic [15:0]    r_r   [wsle_pkg::FRAC];
    wsle_pkg::t_ctx r_ctx [wsle_pkg::FRAC];

    for (genvar g = 0; g < wsle_pkg::FRAC; g++) begin : g_stage
        logic           w_pv;
        logic [16:0]    w_py;
        logic [15:0]    w_pr;
        wsle_pkg::t_ctx w_pc;
        logic [33:0]    w_sq;
        logic [16:0]    n_y;
        logic [15:0]    n_r;

        if (g == 0) begin : g_head
            assign w_pv = i_valid;
            assign w_py = i_y;
            assign w_pr = 16'd0;
            assign w_pc = i_ctx;
        end else begin : g_body
            assign w_pv = r_v[g-1];
            assign w_py = r_y[g-1];
            assign w_pr = r_r[g-1];
            assign w_pc = r_ctx[g-1];
        end

        always_comb begin
            w_sq = 34'(w_py) * 34'(w_py);
            n_r  = w_pr;
            if (w_sq[33]) begin
                n_y = w_sq[33:17];
                n_r[wsle_pkg::FRAC-1-g] = 1'b1;
            end else begin
                n_y = w_sq[32:16];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y[g]   <= n_y;
                r_r[g]   <= n_r;
                r_ctx[g] <= w_pc;
            end
        end
    end

    assign o_valid = r_v[wsle_pkg::FRAC-1];
    assign o_r     = r_r[wsle_pkg::FRAC-1];
    assign o_ctx   = r_ctx[wsle_pkg::FRAC-1];

endmodule

// ===== sv/wsle_back.sv =====
// ----------------------------------------------------------------------------
// wsle_back
// Log2 of both bounds, scaled exponent, exp2 mantissa search, final scale.
// ----------------------------------------------------------------------------
module wsle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_qvalid,
    input  wsle_pkg::t_job i_qjob,
    output logic           o_pop,
    wsle_out_if.source     o_out
);

    function automatic logic [4:0] lead_one(input logic [23:0] x);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (x[i]) begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

    logic w_en;

    logic r_ovalid;
    logic [1:0]  r_species;
    logic [23:0] r_energy;
    logic        r_status;

    assign w_en  = !r_ovalid || o_out.ready;
    assign o_pop = w_en;

    // normalize bounds
    logic           r_a_v;
    wsle_pkg::t_ctx r_a_ctx;
    logic [16:0]    r_a_mlo;
    wsle_pkg::t_ctx n_a_ctx;
    logic [16:0]    n_a_mlo;
    logic [39:0]    w_sh_lo;
    logic [39:0]    w_sh_hi;

    always_comb begin
        n_a_ctx        = '0;
        n_a_ctx.sel    = i_qjob.sel;
        n_a_ctx.status = i_qjob.status;
        n_a_ctx.lo     = i_qjob.lo;
        n_a_ctx.uen    = i_qjob.uen;
        n_a_ctx.n_lo   = lead_one(i_qjob.lo);
        n_a_ctx.n_hi   = lead_one(i_qjob.hi);
        w_sh_lo        = {i_qjob.lo, 16'd0} >> n_a_ctx.n_lo;
        w_sh_hi        = {i_qjob.hi, 16'd0} >> n_a_ctx.n_hi;
        n_a_mlo        = w_sh_lo[16:0];
        n_a_ctx.m_hi   = w_sh_hi[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_qvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ctx <= n_a_ctx;
            r_a_mlo <= n_a_mlo;
        end
    end

    // log2 of lower, then upper bound
    logic           w_p1_v;
    logic [15:0]    w_p1_r;
    wsle_pkg::t_ctx w_p1_ctx;
    wsle_pkg::t_ctx w_p2_in;
    logic           w_p2_v;
    logic [15:0]    w_p2_r;
    wsle_pkg::t_ctx w_p2_ctx;

    wsle_frac_pipe u_log_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_v),
        .i_y     (r_a_mlo),
        .i_ctx   (r_a_ctx),
        .o_valid (w_p1_v),
        .o_r     (w_p1_r),
        .o_ctx   (w_p1_ctx)
    );

    always_comb begin
        w_p2_in      = w_p1_ctx;
        w_p2_in.r_lo = w_p1_r;
    end

    wsle_frac_pipe u_log_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_p1_v),
        .i_y     (w_p1_ctx.m_hi),
        .i_ctx   (w_p2_in),
        .o_valid (w_p2_v),
        .o_r     (w_p2_r),
        .o_ctx   (w_p2_ctx)
    );

    // log ratio, scaled exponent, split into k and f
    logic                r_c_v;
    logic signed [21:0]  r_c_d;
    wsle_pkg::t_ctx      r_c_ctx;
    logic                r_d_v;
    logic signed [38:0]  r_d_p;
    wsle_pkg::t_ctx      r_d_ctx;
    logic                r_e_v;
    wsle_pkg::t_ctx      r_e_ctx;
    logic signed [21:0]  w_lg_hi;
    logic signed [21:0]  w_lg_lo;
    logic signed [16:0]  w_uen_s;
    logic signed [38:0]  w_p;
    logic signed [38:0]  w_e;
    wsle_pkg::t_ctx      n_e_ctx;

    assign w_lg_hi = $signed({1'b0, w_p2_ctx.n_hi, w_p2_r});
    assign w_lg_lo = $signed({1'b0, w_p2_ctx.n_lo, w_p2_ctx.r_lo});
    assign w_uen_s = $signed({1'b0, r_c_ctx.uen});
    assign w_p     = w_uen_s * r_c_d;
    assign w_e     = r_d_p >>> 16;

    always_comb begin
        n_e_ctx     = r_d_ctx;
        n_e_ctx.k   = w_e[22:16];
        n_e_ctx.f   = w_e[15:0];
        n_e_ctx.slo = 17'h10000;
        n_e_ctx.shi = 17'h1ffff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= w_p2_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_d   <= w_lg_hi - w_lg_lo;
            r_c_ctx <= w_p2_ctx;
            r_d_p   <= w_p;
            r_d_ctx <= r_c_ctx;
            r_e_ctx <= n_e_ctx;
        end
    end

    // exp2 mantissa: binary search, one bisection per section
    wsle_pkg::t_ctx w_sctx [wsle_pkg::SEARCH+1];
    logic           w_sv   [wsle_pkg::SEARCH+1];

    assign w_sctx[0] = r_e_ctx;
    assign w_sv[0]   = r_e_v;

    for (genvar j = 0; j < wsle_pkg::SEARCH; j++) begin : g_search
        logic           r_m_v;
        wsle_pkg::t_ctx r_m_ctx;
        wsle_pkg::t_ctx n_m_ctx;
        logic [17:0]    w_sum;
        logic           w_q_v;
        logic [15:0]    w_q_r;
        wsle_pkg::t_ctx w_q_ctx;
        logic           r_u_v;
        wsle_pkg::t_ctx r_u_ctx;
        wsle_pkg::t_ctx n_u_ctx;

        always_comb begin
            n_m_ctx     = w_sctx[j];
            w_sum       = 18'(w_sctx[j].slo) + 18'(w_sctx[j].shi) + 18'd1;
            n_m_ctx.mid = w_sum[17:1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_v <= 1'b0;
                r_u_v <= 1'b0;
            end else if (w_en) begin
                r_m_v <= w_sv[j];
                r_u_v <= w_q_v;
            end
        end

        wsle_frac_pipe u_probe (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_m_v),
            .i_y     (r_m_ctx.mid),
            .i_ctx   (r_m_ctx),
            .o_valid (w_q_v),
            .o_r     (w_q_r),
            .o_ctx   (w_q_ctx)
        );

        always_comb begin
            n_u_ctx = w_q_ctx;
            if (w_q_r <= w_q_ctx.f) begin
                n_u_ctx.slo = w_q_ctx.mid;
            end else begin
                n_u_ctx.shi = w_q_ctx.mid - 17'd1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_m_ctx <= n_m_ctx;
                r_u_ctx <= n_u_ctx;
            end
        end

        assign w_sctx[j+1] = r_u_ctx;
        assign w_sv[j+1]   = r_u_v;
    end

    // scale lower bound by the mantissa
    logic           r_f_v;
    logic [40:0]    r_f_prod;
    wsle_pkg::t_ctx r_f_ctx;
    wsle_pkg::t_ctx w_fin;

    assign w_fin = w_sctx[wsle_pkg::SEARCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= w_sv[wsle_pkg::SEARCH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_prod <= 41'(w_fin.lo) * 41'(w_fin.slo);
            r_f_ctx  <= w_fin;
        end
    end

    // shift by k - 16 and saturate
    localparam logic [47:0] LIMIT = 48'((64'd1 << wsle_pkg::ENERGY_BITS) - 64'd1);

    logic signed [7:0] w_s;
    logic [7:0]        w_neg;
    logic [47:0]       w_shift;
    logic [47:0]       w_sat;
    logic [23:0]       n_energy;

    always_comb begin
        w_s   = $signed({r_f_ctx.k[6], r_f_ctx.k}) - 8'sd16;
        w_neg = 8'(-w_s);
        if (w_s >= 8'sd0) begin
            w_shift = 48'(r_f_prod) << w_s[2:0];
        end else begin
            w_shift = 48'(r_f_prod) >> w_neg[5:0];
        end
        w_sat = (w_shift > LIMIT) ? LIMIT : w_shift;
        if (r_f_ctx.status) begin
            n_energy = 24'd0;
        end else begin
            n_energy = w_sat[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_species <= r_f_ctx.sel;
            r_energy  <= n_energy;
            r_status  <= r_f_ctx.status;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.species    = r_species;
    assign o_out.energy_kev = r_energy;
    assign o_out.status     = r_status;

endmodule

// ===== sv/weighted_species_log_uniform_energy_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_species_log_uniform_energy_unit
// Picks a species from a cumulative table and draws a log-uniform energy.
// ----------------------------------------------------------------------------
// One sample word is taken every cycle and one result word leaves every
// cycle while no result waits. The exp2 mantissa search takes sixteen
// bisections, each a 16-stage squaring pipeline plus a midpoint and an
// update stage, after two such pipelines for the log2 of both bounds.
// The pipeline stalls as a whole while a result waits; a two-word queue
// takes up the words in flight. Registers sit at byte address 8*i on a
// 64-bit APB port; they are to be written only while the unit is idle,
// and the unit itself does not enforce this.
module weighted_species_log_uniform_energy_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsle_in_if.sink     i_in,
    wsle_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    wsle_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry     <= '0;
            r_cfg.count     <= 3'd1;
            r_cfg.floor_kev <= 24'd1;
        end else if (w_wr) begin
            case (w_idx)
                wsle_pkg::REG_ENTRY0: r_cfg.entry[0] <= pwdata;
                wsle_pkg::REG_ENTRY1: r_cfg.entry[1] <= pwdata;
                wsle_pkg::REG_ENTRY2: r_cfg.entry[2] <= pwdata;
                wsle_pkg::REG_ENTRY3: r_cfg.entry[3] <= pwdata;
                wsle_pkg::REG_COUNT:  r_cfg.count <= pwdata[2:0];
                wsle_pkg::REG_FLOOR:  r_cfg.floor_kev <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            wsle_pkg::REG_ENTRY0: prdata = r_cfg.entry[0];
            wsle_pkg::REG_ENTRY1: prdata = r_cfg.entry[1];
            wsle_pkg::REG_ENTRY2: prdata = r_cfg.entry[2];
            wsle_pkg::REG_ENTRY3: prdata = r_cfg.entry[3];
            wsle_pkg::REG_COUNT:  prdata = 64'(r_cfg.count);
            wsle_pkg::REG_FLOOR:  prdata = 64'(r_cfg.floor_kev);
            default:              prdata = 64'd0;
        endcase
    end

    logic           w_push;
    logic           w_full;
    wsle_pkg::t_job w_job;
    logic           w_pop;
    logic           w_qvalid;
    wsle_pkg::t_job w_qjob;

    wsle_front u_front (
        .i_cfg  (r_cfg),
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_job  (w_job)
    );

    wsle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_job   (w_qjob)
    );

    wsle_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (w_qvalid),
        .i_qjob   (w_qjob),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status |-> o_out.energy_kev == 24'd0)
        else $error("status set with nonzero energy");

    a_full_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> $past(o_out.valid && !o_out.ready))
        else $error("queue filled while back end was running");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.energy_kev))
        else $error("stalled result word changed");

endmodule
